>>> design/sha256_pkg.sv
`timescale 1ns / 1ps
package sha256_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_OUT
    } ctrl_state_t;

    // what the word pushed into the buffer is made of
    typedef enum logic [1:0] {
        SRC_DATA,
        SRC_ZERO,
        SRC_LEN_HI,
        SRC_LEN_LO
    } word_src_t;

    typedef struct packed {
        logic      init_chain;
        logic      push;
        word_src_t src;
        logic      load_vars;
        logic      round;
        logic      fold;
        logic      clear_msg;
        logic      add_len;
    } dp_cmd_t;

    typedef struct packed {
        logic [3:0] fill;
    } dp_stat_t;

    localparam logic [31:0] PAD_BYTE = 32'h0000_0080;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

>>> design/sha256_message_hasher_unit.sv
`timescale 1ns / 1ps
// SHA-256 hasher, one word per input transfer.
// A non-final word is accepted and then pushed into the block buffer; a word that fills
// a block adds the 64 rounds (one round per cycle) and a fold into the chain hash.
// The final word adds padding pushes and one or two blocks, then 8 output transfers.
// Reset (rst_n low, async) loads the initial hash and clears length and fill.
module sha256_message_hasher_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] data_word,
    input  logic [2:0]  valid_bytes,
    input  logic        last_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        digest_last
);
    import sha256_pkg::*;

    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic [31:0] word_mux;
    logic [2:0]  bytes_eff;
    logic [5:0]  round_idx;
    logic [2:0]  out_idx;

    sha256_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (data_word),
        .in_count  (valid_bytes),
        .in_last   (last_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd),
        .word_mux  (word_mux),
        .bytes_eff (bytes_eff),
        .round_idx (round_idx),
        .out_idx   (out_idx)
    );

    sha256_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_word    (word_mux),
        .in_bytes   (bytes_eff),
        .round_idx  (round_idx),
        .out_idx    (out_idx),
        .stat       (stat),
        .chain_word (digest_word)
    );

    assign word_index  = out_idx;
    assign digest_last = (out_idx == 3'd7);

endmodule

>>> design/sha256_datapath.sv
`timescale 1ns / 1ps
module sha256_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  sha256_pkg::dp_cmd_t cmd,
    input  logic [31:0]         in_word,
    input  logic [2:0]          in_bytes,
    input  logic [5:0]          round_idx,
    input  logic [2:0]          out_idx,
    output sha256_pkg::dp_stat_t stat,
    output logic [31:0]         chain_word
);
    import sha256_pkg::*;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    logic [31:0] chain_reg [8];
    logic [31:0] sched_reg [16];
    logic [31:0] vars_reg  [8];
    logic [63:0] len_reg;
    logic [3:0]  fill_reg;

    logic [31:0] push_word;
    logic [31:0] w, x15, x2, s0, s1, wn;
    logic [31:0] big0, big1, ch, maj, t1, t2;
    logic [3:0]  ri;

    assign stat.fill  = fill_reg;
    assign chain_word = chain_reg[out_idx];
    assign ri = round_idx[3:0];

    // buffer word selection
    always_comb
    begin
        case (cmd.src)
            SRC_DATA:   push_word = in_word;
            SRC_ZERO:   push_word = '0;
            SRC_LEN_HI: push_word = len_reg[63:32];
            SRC_LEN_LO: push_word = len_reg[31:0];
            default:    push_word = '0;
        endcase
    end

    // schedule expansion and one round
    always_comb
    begin
        x15 = sched_reg[ri + 4'd1];
        x2  = sched_reg[ri + 4'd14];
        s0  = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
        s1  = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
        wn  = sched_reg[ri] + s0 + sched_reg[ri + 4'd9] + s1;
        w   = (round_idx < 6'd16) ? sched_reg[ri] : wn;
        big1 = rotr(vars_reg[4], 6) ^ rotr(vars_reg[4], 11) ^ rotr(vars_reg[4], 25);
        ch   = (vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]);
        t1   = vars_reg[7] + big1 + ch + ROUND_K[round_idx] + w;
        big0 = rotr(vars_reg[0], 2) ^ rotr(vars_reg[0], 13) ^ rotr(vars_reg[0], 22);
        maj  = (vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
             ^ (vars_reg[1] & vars_reg[2]);
        t2   = big0 + maj;
    end

    // control-ish state: length, fill and chain hash
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            fill_reg <= '0;
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= INIT_HASH[i];
        end
        else
        begin
            if (cmd.add_len)
                len_reg <= len_reg + {58'd0, in_bytes, 3'd0};
            if (cmd.push)
                fill_reg <= fill_reg + 4'd1;
            if (cmd.clear_msg)
            begin
                len_reg  <= '0;
                fill_reg <= '0;
            end
            if (cmd.init_chain)
            begin
                for (int i = 0; i < 8; i++)
                    chain_reg[i] <= INIT_HASH[i];
            end
            else if (cmd.fold)
            begin
                for (int i = 0; i < 8; i++)
                    chain_reg[i] <= chain_reg[i] + vars_reg[i];
            end
        end
    end

    // schedule buffer and working variables
    always_ff @(posedge clk)
    begin
        if (cmd.push)
            sched_reg[fill_reg] <= push_word;
        else if (cmd.round && round_idx >= 6'd16)
            sched_reg[ri] <= wn;
        if (cmd.load_vars)
        begin
            for (int i = 0; i < 8; i++)
                vars_reg[i] <= chain_reg[i];
        end
        else if (cmd.round)
        begin
            vars_reg[7] <= vars_reg[6];
            vars_reg[6] <= vars_reg[5];
            vars_reg[5] <= vars_reg[4];
            vars_reg[4] <= vars_reg[3] + t1;
            vars_reg[3] <= vars_reg[2];
            vars_reg[2] <= vars_reg[1];
            vars_reg[1] <= vars_reg[0];
            vars_reg[0] <= t1 + t2;
        end
    end

endmodule

>>> design/sha256_ctrl.sv
`timescale 1ns / 1ps
module sha256_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [31:0]          in_data,
    input  logic [2:0]           in_count,
    input  logic                 in_last,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  sha256_pkg::dp_stat_t stat,
    output sha256_pkg::dp_cmd_t  cmd,
    output logic [31:0]          word_mux,
    output logic [2:0]           bytes_eff,
    output logic [5:0]           round_idx,
    output logic [2:0]           out_idx
);
    import sha256_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic [5:0]  round_reg, round_next;
    logic [2:0]  oidx_reg, oidx_next;
    // pad progress is kept in the three flags below
    logic        fin_reg, fin_next;      // final word seen
    logic        pad80_reg, pad80_next;  // standalone 0x80 word still owed
    logic [1:0]  len_reg, len_next;      // length words pushed
    logic [31:0] word_reg;
    logic [2:0]  nb_reg;
    logic        accept;
    logic [31:0] mask;

    assign accept    = in_valid && in_ready;
    assign round_idx = round_reg;
    assign out_idx   = oidx_reg;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign bytes_eff = nb_reg;

    // capture the word and its effective byte count
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= in_data;
            if (!in_last || in_count > 3'd4)
                nb_reg <= 3'd4;
            else
                nb_reg <= in_count;
        end
    end

    // data word with masking and pad byte for the final word
    always_comb
    begin
        mask = '1;
        case (nb_reg)
            3'd0:    mask = 32'h0000_0000;
            3'd1:    mask = 32'hff00_0000;
            3'd2:    mask = 32'hffff_0000;
            3'd3:    mask = 32'hffff_ff00;
            default: mask = 32'hffff_ffff;
        endcase
        if (pad80_reg)
            word_mux = PAD_BYTE << 24;
        else if (fin_reg && nb_reg != 3'd4)
            word_mux = (word_reg & mask) | (PAD_BYTE << (5'd24 - {nb_reg[1:0], 3'd0}));
        else
            word_mux = word_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            round_reg <= '0;
            oidx_reg  <= '0;
            fin_reg   <= 1'b0;
            pad80_reg <= 1'b0;
            len_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            oidx_reg  <= oidx_next;
            fin_reg   <= fin_next;
            pad80_reg <= pad80_next;
            len_reg   <= len_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        oidx_next  = oidx_reg;
        fin_next   = fin_reg;
        pad80_next = pad80_reg;
        len_next   = len_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_PUSH;
                    fin_next   = in_last;
                    pad80_next = 1'b0;
                    len_next   = '0;
                end
            end
            ST_PUSH:
            begin
                // pushes data word (or a 0x80 word) then decides
                if (fin_reg && nb_reg == 3'd4 && !pad80_reg)
                    pad80_next = 1'b1;
                else
                    pad80_next = 1'b0;
                if (stat.fill == 4'd15)
                begin
                    state_next = ST_ROUND;
                    round_next = '0;
                end
                else if (fin_reg)
                    state_next = (fin_reg && nb_reg == 3'd4 && !pad80_reg) ? ST_PUSH : ST_PAD;
                else
                    state_next = ST_IDLE;
            end
            ST_ROUND:
            begin
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                if (!fin_reg)
                    state_next = ST_IDLE;
                else if (len_reg == 2'd2)
                begin
                    state_next = ST_OUT;
                    oidx_next  = '0;
                end
                else if (pad80_reg)
                    state_next = ST_PUSH;
                else
                    state_next = ST_PAD;
            end
            ST_PAD:
            begin
                // length goes in slots 14 and 15 of one block only
                if (stat.fill == 4'd14 || (stat.fill == 4'd15 && len_reg == 2'd1))
                    len_next = len_reg + 2'd1;
                if (stat.fill == 4'd15)
                begin
                    state_next = ST_ROUND;
                    round_next = '0;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7)
                    begin
                        state_next = ST_IDLE;
                        fin_next   = 1'b0;
                        len_next   = '0;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd = '0;
        cmd.src = SRC_DATA;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.add_len = 1'b0;
            end
            ST_PUSH:
            begin
                cmd.push    = 1'b1;
                cmd.src     = SRC_DATA;
                cmd.add_len = !pad80_reg;
                cmd.load_vars = (stat.fill == 4'd15);
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
            end
            ST_FOLD:
            begin
                cmd.fold = 1'b1;
            end
            ST_PAD:
            begin
                cmd.push = 1'b1;
                if (stat.fill == 4'd14)
                    cmd.src = SRC_LEN_HI;
                else if (stat.fill == 4'd15 && len_reg == 2'd1)
                    cmd.src = SRC_LEN_LO;
                else
                    cmd.src = SRC_ZERO;
                cmd.load_vars = (stat.fill == 4'd15);
            end
            ST_OUT:
            begin
                if (out_ready && oidx_reg == 3'd7)
                begin
                    cmd.init_chain = 1'b1;
                    cmd.clear_msg  = 1'b1;
                end
            end
            default: cmd = '0;
        endcase
    end

endmodule

>>> verif/sha256_message_hasher_unit_tb.sv
`timescale 1ns / 1ps
module sha256_message_hasher_unit_tb;

    // one digest word as the block should emit it
    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_item_t;

    // SHA-256 predictor plus queue of pending digest words
    class digest_scoreboard;
        logic [31:0] chain [8];
        logic [31:0] sched [16];
        logic [63:0] msg_bits;
        int          fill;
        digest_item_t pending [$];
        int          errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 8; i++)
                chain[i] = sha256_pkg::INIT_HASH[i];
            msg_bits = '0;
            fill = 0;
        endfunction

        function logic [31:0] rotr(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            logic [31:0] v [8];
            logic [31:0] w, x15, x2, t1, t2, e, a;
            for (int i = 0; i < 8; i++)
                v[i] = chain[i];
            for (int r = 0; r < 64; r++)
            begin
                if (r < 16)
                    w = sched[r];
                else
                begin
                    x15 = sched[(r - 15) & 15];
                    x2 = sched[(r - 2) & 15];
                    w = sched[r & 15]
                        + (rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3))
                        + sched[(r - 7) & 15]
                        + (rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10));
                    sched[r & 15] = w;
                end
                e = v[4];
                a = v[0];
                t1 = v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
                     + ((e & v[5]) ^ (~e & v[6])) + sha256_pkg::ROUND_K[r] + w;
                t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
                     + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
                v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++)
                chain[i] += v[i];
        endfunction

        function void buffer_word(logic [31:0] w);
            sched[fill] = w;
            fill = (fill + 1) & 15;
            if (fill == 0)
                compress();
        endfunction

        // note one accepted input transfer
        function void note_input(logic [31:0] data, logic [2:0] nb, logic lst);
            digest_item_t it;
            int n;
            logic [31:0] mask;
            if (!lst)
            begin
                msg_bits += 32;
                buffer_word(data);
                return;
            end
            n = (nb > 4) ? 4 : nb;
            msg_bits += 8 * n;
            if (n == 4)
            begin
                buffer_word(data);
                buffer_word(32'h8000_0000);
            end
            else
            begin
                mask = (n == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * n));
                buffer_word((data & mask) | (sha256_pkg::PAD_BYTE << (24 - 8 * n)));
            end
            while (fill != 14)
                buffer_word(32'h0);
            buffer_word(msg_bits[63:32]);
            buffer_word(msg_bits[31:0]);
            for (int i = 0; i < 8; i++)
            begin
                it.word = chain[i];
                it.idx = i[2:0];
                it.last = (i == 7);
                pending.push_back(it);
            end
            restart();
        endfunction

        // compare one output transfer with the oldest expectation
        function void check_output(logic [31:0] w, logic [2:0] idx, logic lst);
            digest_item_t ex;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected digest word %h idx %0d", $time, w, idx);
                errors++;
                return;
            end
            ex = pending.pop_front();
            if (w !== ex.word)
            begin
                $display("%0t: digest_word exp %h got %h", $time, ex.word, w);
                errors++;
            end
            if (idx !== ex.idx)
            begin
                $display("%0t: word_index exp %0d got %0d", $time, ex.idx, idx);
                errors++;
            end
            if (lst !== ex.last)
            begin
                $display("%0t: digest_last exp %0d got %0d", $time, ex.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        last_word;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_last;

    digest_scoreboard sb;
    bit  hold_off;
    bit  stim_done;
    int  cycle_count;

    sha256_message_hasher_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_word   (data_word),
        .valid_bytes (valid_bytes),
        .last_word   (last_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digest_word (digest_word),
        .word_index  (word_index),
        .digest_last (digest_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // timeout guard
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 400000)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // send one word: random gap, then hold until transfer
    task automatic send_word(logic [31:0] d, logic [2:0] nb, logic lst);
        int gap;
        gap = $urandom_range(0, 4);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        data_word <= d;
        valid_bytes <= nb;
        last_word <= lst;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(d, nb, lst);
        @(negedge clk);
    endtask

    // a message of n full words then a final word with count nb
    task automatic send_message(int n, logic [2:0] nb);
        for (int i = 0; i < n; i++)
            send_word($urandom, ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd4,
                      1'b0);
        send_word($urandom, nb, 1'b1);
    endtask

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_ready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_off = 1'b0;
            end
            out_ready <= ($urandom_range(0, 4) == 0) ? 1'b0 : 1'b1;
        end
    end

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_output(digest_word, word_index, digest_last);
    end

    initial
    begin
        int words;
        sb = new();
        hold_off = 1'b0;
        stim_done = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_word = '0;
        valid_bytes = '0;
        last_word = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty message, final byte counts 0, 1, 3, 4 and above 4, block edges
        send_word(32'hffff_ffff, 3'd0, 1'b1);
        send_word(32'hffff_ffff, 3'd1, 1'b1);
        send_word(32'h6162_63ff, 3'd3, 1'b1);
        send_word(32'h0000_0000, 3'd4, 1'b1);
        send_word(32'hffff_ffff, 3'd7, 1'b1);
        send_word(32'hffff_ffff, 3'd2, 1'b0);
        send_word(32'h0000_0000, 3'd5, 1'b1);
        send_message(13, 3'd4);
        send_message(14, 3'd0);

        // long receiver stall while the sender keeps offering words; in_ready stays low until the digest is read
        hold_off = 1'b1;
        send_message(3, 3'd4);
        send_message(1, 3'd2);
        send_message(2, 3'd1);

        // random messages, mostly short
        words = 0;
        while (words < 115)
        begin
            int n;
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 33) : $urandom_range(0, 6);
            send_message(n, 3'($urandom_range(0, 7)));
            words += n + 1;
        end
        in_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> filelist.f
design/sha256_pkg.sv
design/sha256_datapath.sv
design/sha256_ctrl.sv
design/sha256_message_hasher_unit.sv
verif/sha256_message_hasher_unit_tb.sv
